>>> hdl/fixed_block_free_list_allocator_unit_macros.svh
// Assertion macros used by the allocator back end.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH

// Checked at every rising edge outside reset.
`define FBFL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fbfl assertion failed");

// The same, with a message of the caller's choosing.
`define FBFL_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

>>> hdl/fbfl_pkg.sv
package fbfl_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;

    localparam int IDX_IN_W   = 10;
    localparam int SIZE_W     = 13;
    localparam int COUNT_W    = 11;
    localparam int OFFSET_W   = 22;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 13'd64;
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;
    localparam logic [SIZE_W-1:0]  SIZE_MIN        = 13'd8;
    localparam logic [SIZE_W-1:0]  SIZE_MAX        = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_SIZE  = 2'd0,
        CFG_BLOCK_COUNT = 2'd1
    } t_cfg_reg;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_BAD   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_RUN   = 2'd1,
        BK_POP   = 2'd2
    } t_back_state;

    typedef struct packed {
        t_kind                kind;
        logic [IDX_IN_W-1:0]  idx;
    } t_cmd;

    typedef struct packed {
        t_status              status;
        logic [IDX_IN_W-1:0]  grant;
    } t_res;

    // Effective block size: clamped to 8..4096 and rounded up to a multiple of 8.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] c;
        logic [SIZE_W-1:0] r;
        c = s;
        if (c > SIZE_MAX) begin
            c = SIZE_MAX;
        end
        if (c < SIZE_MIN) begin
            c = SIZE_MIN;
        end
        r = c + 13'd7;
        return {r[SIZE_W-1:3], 3'b000};
    endfunction

endpackage

>>> hdl/fbfl_req_if.sv
interface fbfl_req_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [fbfl_pkg::IDX_IN_W-1:0]  block_index;

    modport source (output valid, output op, output block_index, input ready);
    modport sink   (input valid, input op, input block_index, output ready);
endinterface

>>> hdl/fbfl_rsp_if.sv
interface fbfl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [fbfl_pkg::IDX_IN_W-1:0]  granted_index;
    logic [fbfl_pkg::OFFSET_W-1:0]  byte_offset;

    modport source (output valid, output status, output granted_index, output byte_offset,
                    input ready);
    modport sink   (input valid, input status, input granted_index, input byte_offset,
                    output ready);
endinterface

>>> hdl/fixed_block_free_list_allocator_unit.sv
// Channel   Dir   Modport  Payload
// i_req     in    sink     op, block_index
// o_rsp     out   source   status, granted_index, byte_offset
// i_cfg_*   in    -        register index, write data
//
// A free is handled in the run state; an allocate also passes the pop state, as the link memory read is registered.
// Requests pass a two-entry queue, the back end and a registered output with the offset multiply.
// After reset and after every count register write all MAX_BLOCKS entries of the link memory are rebuilt.
// No request is taken during the rebuild; configuration writes are.
// The output register lets the back end keep working while a result waits to be taken.
module fixed_block_free_list_allocator_unit #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fbfl_req_if.sink                         i_req,
    fbfl_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [fbfl_pkg::SIZE_W-1:0]  r_blk_size;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             w_count_wr, w_count_rst;
    logic [fbfl_pkg::COUNT_W-1:0] w_count_raw;
    logic                         w_size_we, w_count_we;
    logic                         w_clearing;
    logic                         w_cmd_valid, w_cmd_ready;
    fbfl_pkg::t_cmd               w_cmd;
    logic                         w_res_valid, w_res_ready;
    fbfl_pkg::t_res               w_res;

    assign w_count_raw = i_cfg_data[fbfl_pkg::COUNT_W-1:0];
    assign w_size_we   = i_cfg_we && (i_cfg_index == fbfl_pkg::CFG_BLOCK_SIZE);
    assign w_count_we  = i_cfg_we && (i_cfg_index == fbfl_pkg::CFG_BLOCK_COUNT);
    assign w_count_wr  = (32'(w_count_raw) > 32'(MAX_BLOCKS)) ?
                         CNT_W'(MAX_BLOCKS) : CNT_W'(w_count_raw);
    assign w_count_rst = (32'(fbfl_pkg::BLOCK_COUNT_RST) > 32'(MAX_BLOCKS)) ?
                         CNT_W'(MAX_BLOCKS) : CNT_W'(fbfl_pkg::BLOCK_COUNT_RST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_size <= fbfl_pkg::eff_size(fbfl_pkg::BLOCK_SIZE_RST);
            r_count    <= w_count_rst;
        end else begin
            if (w_size_we) begin
                r_blk_size <= fbfl_pkg::eff_size(i_cfg_data);
            end
            if (w_count_we) begin
                r_count <= w_count_wr;
            end
        end
    end

    fbfl_front #(
        .CNT_W (CNT_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_count     (r_count),
        .i_busy      (w_clearing),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    fbfl_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rebuild   (w_count_we),
        .i_count     (r_count),
        .o_clearing  (w_clearing),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    fbfl_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .i_blk_size  (r_blk_size),
        .o_rsp       (o_rsp)
    );

endmodule

>>> hdl/fbfl_front.sv
module fbfl_front #(
    parameter int CNT_W = fbfl_pkg::COUNT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fbfl_req_if.sink           i_req,
    input  logic [CNT_W-1:0]   i_count,
    input  logic               i_busy,
    output logic               o_cmd_valid,
    output fbfl_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_ready
);

    localparam int QPTR_W = (fbfl_pkg::QUEUE_DEPTH > 1) ? $clog2(fbfl_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(fbfl_pkg::QUEUE_DEPTH + 1);

    fbfl_pkg::t_cmd    r_q [fbfl_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_fill, n_fill;
    logic              w_push, w_pop, w_full;
    fbfl_pkg::t_cmd    w_cmd;

    assign w_full      = (r_fill == QCNT_W'(fbfl_pkg::QUEUE_DEPTH));
    assign i_req.ready = !w_full && !i_busy;
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        w_cmd.idx = i_req.block_index;
        if (i_req.op == fbfl_pkg::OP_FREE) begin
            if (32'(i_req.block_index) < 32'(i_count)) begin
                w_cmd.kind = fbfl_pkg::CMD_FREE;
            end else begin
                w_cmd.kind = fbfl_pkg::CMD_BAD;
            end
        end else begin
            w_cmd.kind = fbfl_pkg::CMD_ALLOC;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (w_push) begin
            n_wr_ptr = (32'(r_wr_ptr) == fbfl_pkg::QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (32'(r_rd_ptr) == fbfl_pkg::QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

>>> hdl/fbfl_back.sv
`include "fixed_block_free_list_allocator_unit_macros.svh"

module fbfl_back #(
    parameter int MAX_BLOCKS = fbfl_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W      = fbfl_pkg::IDX_IN_W,
    parameter int CNT_W      = fbfl_pkg::COUNT_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rebuild,
    input  logic [CNT_W-1:0]   i_count,
    output logic               o_clearing,
    input  logic               i_cmd_valid,
    input  fbfl_pkg::t_cmd     i_cmd,
    output logic               o_cmd_ready,
    output logic               o_res_valid,
    output fbfl_pkg::t_res     o_res,
    input  logic               i_res_ready
);

    fbfl_pkg::t_back_state r_state, n_state;
    logic [IDX_W-1:0]      r_ptr, n_ptr;
    logic [IDX_W-1:0]      r_head, n_head;
    logic                  r_hv, n_hv;
    logic [IDX_W-1:0]      r_grant, n_grant;
    logic                  r_res_valid;
    fbfl_pkg::t_res        r_res, n_res;
    logic                  w_load_res;
    logic                  w_res_free;

    logic [IDX_W:0]        r_mem [MAX_BLOCKS];
    logic [IDX_W:0]        r_rd;
    logic                  w_we, w_re;
    logic [IDX_W-1:0]      w_waddr, w_raddr;
    logic [IDX_W:0]        w_wdata;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_ptr_dec;
    logic [31:0]           w_idx_ext, w_grant_ext;
    logic                  w_res_hold, w_free_take, w_run_hv, w_head_ok;

    assign w_idx_ext   = 32'(i_cmd.idx);
    assign w_idx       = w_idx_ext[IDX_W-1:0];
    assign w_grant_ext = 32'(r_grant);
    assign w_ptr_dec   = r_ptr - 1'b1;
    assign w_res_free  = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_clearing  = (r_state == fbfl_pkg::BK_CLEAR);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_head      = r_head;
        n_hv        = r_hv;
        n_grant     = r_grant;
        w_we        = 1'b0;
        w_waddr     = r_ptr;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_head;
        o_cmd_ready = 1'b0;
        w_load_res  = 1'b0;
        n_res       = r_res;
        case (r_state)
            fbfl_pkg::BK_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = {(r_ptr != '0), w_ptr_dec};
                n_ptr   = r_ptr + 1'b1;
                n_hv    = (i_count != '0);
                n_head  = (i_count != '0) ? IDX_W'(i_count - 1'b1) : '0;
                if (r_ptr == IDX_W'(MAX_BLOCKS - 1)) begin
                    n_state = fbfl_pkg::BK_RUN;
                end
            end
            fbfl_pkg::BK_RUN: begin
                o_cmd_ready = w_res_free;
                if (i_cmd_valid && w_res_free) begin
                    case (i_cmd.kind)
                        fbfl_pkg::CMD_FREE: begin
                            w_we         = 1'b1;
                            w_waddr      = w_idx;
                            w_wdata      = {r_hv, r_head};
                            n_head       = w_idx;
                            n_hv         = 1'b1;
                            w_load_res   = 1'b1;
                            n_res.status = fbfl_pkg::ST_OK;
                            n_res.grant  = i_cmd.idx;
                        end
                        fbfl_pkg::CMD_ALLOC: begin
                            if (r_hv && (32'(r_head) < 32'(i_count))) begin
                                w_re    = 1'b1;
                                w_raddr = r_head;
                                n_grant = r_head;
                                n_state = fbfl_pkg::BK_POP;
                            end else begin
                                w_load_res   = 1'b1;
                                n_res.status = fbfl_pkg::ST_EMPTY;
                                n_res.grant  = '0;
                            end
                        end
                        default: begin
                            w_load_res   = 1'b1;
                            n_res.status = fbfl_pkg::ST_RANGE;
                            n_res.grant  = '0;
                        end
                    endcase
                end
            end
            fbfl_pkg::BK_POP: begin
                if (w_res_free) begin
                    n_head       = r_rd[IDX_W-1:0];
                    n_hv         = r_rd[IDX_W];
                    w_load_res   = 1'b1;
                    n_res.status = fbfl_pkg::ST_OK;
                    n_res.grant  = w_grant_ext[fbfl_pkg::IDX_IN_W-1:0];
                    n_state      = fbfl_pkg::BK_RUN;
                end
            end
            default: begin
                n_state = fbfl_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_rebuild) begin
            r_state     <= fbfl_pkg::BK_CLEAR;
            r_ptr       <= '0;
            r_hv        <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_hv    <= n_hv;
            if (w_load_res) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_grant <= n_grant;
        if (w_load_res) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    assign w_res_hold  = r_res_valid && !i_res_ready && !i_rebuild;
    assign w_free_take = (r_state == fbfl_pkg::BK_RUN) && i_cmd_valid && o_cmd_ready &&
                         (i_cmd.kind == fbfl_pkg::CMD_FREE) && !i_rebuild;
    assign w_run_hv    = (r_state == fbfl_pkg::BK_RUN) && r_hv;
    assign w_head_ok   = (32'(r_head) < 32'(i_count));

    `FBFL_ASSERT(a_no_cmd_in_clear, i_clk, i_rst_n, o_clearing |-> !o_cmd_ready)
    `FBFL_ASSERT(a_res_held, i_clk, i_rst_n, w_res_hold |=> (r_res_valid && $stable(r_res)))
    `FBFL_ASSERT_MSG(a_free_head, i_clk, i_rst_n, w_free_take |=> r_hv, "free left the list empty")
    `FBFL_ASSERT_MSG(a_head_in_pool, i_clk, i_rst_n, w_run_hv |-> w_head_ok, "head outside the pool")

endmodule

>>> hdl/fbfl_out.sv
module fbfl_out (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_res_valid,
    input  fbfl_pkg::t_res               i_res,
    output logic                         o_res_ready,
    input  logic [fbfl_pkg::SIZE_W-1:0]  i_blk_size,
    fbfl_rsp_if.source                   o_rsp
);

    localparam int PROD_W = fbfl_pkg::IDX_IN_W + fbfl_pkg::SIZE_W;

    logic                            r_valid;
    fbfl_pkg::t_status               r_status;
    logic [fbfl_pkg::IDX_IN_W-1:0]   r_grant;
    logic [fbfl_pkg::OFFSET_W-1:0]   r_offset;
    logic [PROD_W-1:0]               w_prod;
    logic                            w_load;

    assign o_res_ready = !r_valid || o_rsp.ready;
    assign w_load      = i_res_valid && o_res_ready;
    assign w_prod      = PROD_W'(i_res.grant) * PROD_W'(i_blk_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= i_res.status;
            r_grant  <= i_res.grant;
            r_offset <= (i_res.status == fbfl_pkg::ST_OK) ?
                        w_prod[fbfl_pkg::OFFSET_W-1:0] : '0;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.granted_index = r_grant;
    assign o_rsp.byte_offset   = r_offset;

endmodule
